// ===== design/cuart_pkg.sv =====
package cuart_pkg;

    // Default FIFO depth for both directions
    localparam int DEFAULT_QUEUE_DEPTH = 16;

    // Operation carried by one input word
    typedef enum logic [2:0] {
        MODE_CTRL_WR   = 3'd0,
        MODE_TX_WR     = 3'd1,
        MODE_RX_RD     = 3'd2,
        MODE_STAT_POLL = 3'd3,
        MODE_TICK      = 3'd4,
        MODE_HOST_PUSH = 3'd5,
        MODE_HOST_POP  = 3'd6
    } t_mode;

    typedef logic [7:0] t_byte;
    typedef logic [4:0] t_level;

    // Status byte bit positions
    localparam int ST_RX_FULL_BIT  = 0;
    localparam int ST_TX_SPACE_BIT = 1;
    localparam int ST_BUSY_BIT     = 2;
    localparam int ST_TX_IRQ_BIT   = 6;
    localparam int ST_RX_IRQ_BIT   = 7;

    // Control byte bit positions
    localparam int CT_RESET_BIT    = 0;
    localparam int CT_TX_IRQ_BIT   = 6;
    localparam int CT_RX_IRQ_BIT   = 7;

endpackage

// ===== design/console_uart_with_fifos.sv =====
// Console UART between a guest CPU and a host, with a transmit and a receive FIFO.
// Input channel: i_in_valid / o_in_stall carries one word per operation: i_mode
// selects control write, transmit write, receive read, status poll, task tick,
// host push or host pop; i_data_in holds the byte where the operation has one.
// Output channel: o_out_valid / i_out_stall returns exactly one result word per
// input word: status after the operation, the receive holding register as it
// stood before it, the popped host byte with its valid flag, the IRQ line and
// both FIFO levels.
// Each accepted word's result is registered at the edge that accepts it. Throughput
// is one word per cycle while the receiver does not stall; the operation settles
// in a single pass of logic between the accepted word and the result register,
// and each FIFO keeps its head entry in a registered read port for a direct pop.
// While the receiver stalls with a result waiting, the result register holds and
// the input channel stalls too; with no result waiting the input is still taken.
// Reset (synchronous, active low) empties both FIFOs, clears enables, control
// latch and receive holding register, and leaves only the transmit space flag set.
module console_uart_with_fifos #(
    parameter int QUEUE_DEPTH = cuart_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [2:0]       i_mode,
    input  cuart_pkg::t_byte i_data_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output cuart_pkg::t_byte o_status,
    output cuart_pkg::t_byte o_read_byte,
    output cuart_pkg::t_byte o_host_byte,
    output logic             o_host_byte_valid,
    output logic             o_irq,
    output cuart_pkg::t_level o_tx_level,
    output cuart_pkg::t_level o_rx_level
);
    import cuart_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    // FIFO storage
    t_byte r_tx_mem [QUEUE_DEPTH];
    t_byte r_rx_mem [QUEUE_DEPTH];
    t_byte r_tx_rd, r_rx_rd;

    // FIFO pointers and counts
    logic [PW-1:0] r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [PW-1:0] r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [CW-1:0] r_tx_count, n_tx_count, r_rx_count, n_rx_count;
    logic          tx_we, rx_we;

    // Status, control and holding state
    t_byte r_rx_holding, n_rx_holding;
    logic  r_rx_full, n_rx_full, r_tx_space, n_tx_space, r_busy, n_busy;
    logic  r_tx_irq, n_tx_irq, r_rx_irq, n_rx_irq;
    logic  r_ctl_reset, n_ctl_reset;
    logic  r_en_tx, n_en_tx, r_en_rx, n_en_rx;

    // Result word
    logic  r_out_valid;
    t_byte r_status, r_read_byte, r_host_byte;
    logic  r_host_byte_valid;
    t_level r_tx_level, r_rx_level;

    t_byte n_status, n_host_byte;
    logic  n_host_byte_valid;
    logic  in_accept;
    t_mode mode;
    logic  do_tx_refresh, do_rx_refresh, rx_guest_read;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;
    assign mode       = t_mode'(i_mode);

    // Operation decode and next state
    always_comb begin
        logic rx_full_v;
        n_tx_head    = r_tx_head;
        n_tx_tail    = r_tx_tail;
        n_tx_count   = r_tx_count;
        n_rx_head    = r_rx_head;
        n_rx_tail    = r_rx_tail;
        n_rx_count   = r_rx_count;
        n_rx_holding = r_rx_holding;
        n_rx_full    = r_rx_full;
        n_tx_space   = r_tx_space;
        n_busy       = r_busy;
        n_tx_irq     = r_tx_irq;
        n_rx_irq     = r_rx_irq;
        n_ctl_reset  = r_ctl_reset;
        n_en_tx      = r_en_tx;
        n_en_rx      = r_en_rx;
        tx_we        = 1'b0;
        rx_we        = 1'b0;
        n_host_byte       = '0;
        n_host_byte_valid = 1'b0;
        do_tx_refresh = 1'b0;
        do_rx_refresh = 1'b0;
        rx_guest_read = 1'b0;
        rx_full_v     = r_rx_full;

        if (in_accept) begin
            unique case (mode)
                MODE_CTRL_WR: begin
                    n_ctl_reset = i_data_in[CT_RESET_BIT];
                    if (i_data_in[CT_RESET_BIT]) begin
                        // busy alone
                        n_rx_full  = 1'b0;
                        n_tx_space = 1'b0;
                        n_busy     = 1'b1;
                        n_tx_irq   = 1'b0;
                        n_rx_irq   = 1'b0;
                    end else begin
                        n_en_tx = i_data_in[CT_TX_IRQ_BIT];
                        n_en_rx = i_data_in[CT_RX_IRQ_BIT];
                    end
                end
                MODE_TX_WR: begin
                    if (!r_busy) begin
                        if (r_tx_count < FULL_CNT) begin
                            tx_we      = 1'b1;
                            n_tx_tail  = (r_tx_tail == LAST_PTR) ? '0 : r_tx_tail + 1'b1;
                            n_tx_count = r_tx_count + 1'b1;
                        end
                        do_tx_refresh = 1'b1;
                    end
                end
                MODE_RX_RD: begin
                    if (!r_busy) begin
                        do_rx_refresh = 1'b1;
                        rx_guest_read = 1'b1;
                    end
                end
                MODE_STAT_POLL: begin
                    if (!r_busy) begin
                        do_tx_refresh = 1'b1;
                        do_rx_refresh = 1'b1;
                    end
                end
                MODE_TICK: begin
                    if (r_ctl_reset) begin
                        n_ctl_reset = 1'b0;
                        n_rx_full   = 1'b0;
                        n_tx_space  = 1'b0;
                        n_busy      = 1'b1;
                        n_tx_irq    = 1'b0;
                        n_rx_irq    = 1'b0;
                    end else if (r_busy) begin
                        // second tick of the reset sequence; holding register kept
                        n_tx_head  = '0;
                        n_tx_tail  = '0;
                        n_tx_count = '0;
                        n_rx_head  = '0;
                        n_rx_tail  = '0;
                        n_rx_count = '0;
                        n_en_tx    = 1'b0;
                        n_en_rx    = 1'b0;
                        n_rx_full  = 1'b0;
                        n_tx_space = 1'b1;
                        n_busy     = 1'b0;
                        n_tx_irq   = 1'b0;
                        n_rx_irq   = 1'b0;
                    end else begin
                        do_tx_refresh = 1'b1;
                        do_rx_refresh = 1'b1;
                    end
                end
                MODE_HOST_PUSH: begin
                    if (r_rx_count < FULL_CNT) begin
                        rx_we      = 1'b1;
                        n_rx_tail  = (r_rx_tail == LAST_PTR) ? '0 : r_rx_tail + 1'b1;
                        n_rx_count = r_rx_count + 1'b1;
                    end
                end
                MODE_HOST_POP: begin
                    if (r_tx_count != '0) begin
                        n_host_byte       = r_tx_rd;
                        n_host_byte_valid = 1'b1;
                        n_tx_head  = (r_tx_head == LAST_PTR) ? '0 : r_tx_head + 1'b1;
                        n_tx_count = r_tx_count - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // Transmit flags follow the count after a transmit write, status poll or tick
        if (do_tx_refresh) begin
            n_tx_space = (n_tx_count < FULL_CNT);
            n_tx_irq   = (n_tx_count < FULL_CNT) & r_en_tx;
        end

        // Holding register reload from the receive FIFO
        if (do_rx_refresh) begin
            if (rx_guest_read || !r_rx_full) begin
                rx_full_v = (r_rx_count != '0);
                if (rx_full_v) begin
                    n_rx_holding = r_rx_rd;
                    n_rx_head    = (r_rx_head == LAST_PTR) ? '0 : r_rx_head + 1'b1;
                    n_rx_count   = r_rx_count - 1'b1;
                end
            end
            n_rx_full = rx_full_v;
            n_rx_irq  = rx_full_v & r_en_rx;
        end
    end

    // Status byte after the operation
    always_comb begin
        n_status                  = '0;
        n_status[ST_RX_FULL_BIT]  = n_rx_full;
        n_status[ST_TX_SPACE_BIT] = n_tx_space;
        n_status[ST_BUSY_BIT]     = n_busy;
        n_status[ST_TX_IRQ_BIT]   = n_tx_irq;
        n_status[ST_RX_IRQ_BIT]   = n_rx_irq;
    end

    // FIFO memories: one write port, registered head read with write bypass
    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            r_tx_mem[r_tx_tail] <= i_data_in;
        end
        r_tx_rd <= (tx_we && (r_tx_tail == n_tx_head)) ? i_data_in : r_tx_mem[n_tx_head];
        if (rx_we) begin
            r_rx_mem[r_rx_tail] <= i_data_in;
        end
        r_rx_rd <= (rx_we && (r_rx_tail == n_rx_head)) ? i_data_in : r_rx_mem[n_rx_head];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_head    <= '0;
            r_tx_tail    <= '0;
            r_tx_count   <= '0;
            r_rx_head    <= '0;
            r_rx_tail    <= '0;
            r_rx_count   <= '0;
            r_rx_holding <= '0;
            r_rx_full    <= 1'b0;
            r_tx_space   <= 1'b1;
            r_busy       <= 1'b0;
            r_tx_irq     <= 1'b0;
            r_rx_irq     <= 1'b0;
            r_ctl_reset  <= 1'b0;
            r_en_tx      <= 1'b0;
            r_en_rx      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_tx_head    <= n_tx_head;
            r_tx_tail    <= n_tx_tail;
            r_tx_count   <= n_tx_count;
            r_rx_head    <= n_rx_head;
            r_rx_tail    <= n_rx_tail;
            r_rx_count   <= n_rx_count;
            r_rx_holding <= n_rx_holding;
            r_rx_full    <= n_rx_full;
            r_tx_space   <= n_tx_space;
            r_busy       <= n_busy;
            r_tx_irq     <= n_tx_irq;
            r_rx_irq     <= n_rx_irq;
            r_ctl_reset  <= n_ctl_reset;
            r_en_tx      <= n_en_tx;
            r_en_rx      <= n_en_rx;
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_status          <= n_status;
            r_read_byte       <= r_rx_holding;
            r_host_byte       <= n_host_byte;
            r_host_byte_valid <= n_host_byte_valid;
            r_tx_level        <= t_level'(n_tx_count);
            r_rx_level        <= t_level'(n_rx_count);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_read_byte       = r_read_byte;
    assign o_host_byte       = r_host_byte;
    assign o_host_byte_valid = r_host_byte_valid;
    assign o_irq             = r_status[ST_TX_IRQ_BIT] | r_status[ST_RX_IRQ_BIT];
    assign o_tx_level        = r_tx_level;
    assign o_rx_level        = r_rx_level;

endmodule

// ===== design/cuart_checker.sv =====
module cuart_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [2:0]        i_mode,
    input cuart_pkg::t_byte  i_data_in,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input cuart_pkg::t_byte  o_status,
    input cuart_pkg::t_byte  o_read_byte,
    input cuart_pkg::t_byte  o_host_byte,
    input logic              o_host_byte_valid,
    input logic              o_irq,
    input cuart_pkg::t_level o_tx_level,
    input cuart_pkg::t_level o_rx_level
);
    import cuart_pkg::*;

    // IRQ line follows the two status IRQ bits
    a_irq_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_irq == (o_status[ST_TX_IRQ_BIT] | o_status[ST_RX_IRQ_BIT])))
        else $error("irq does not match status IRQ bits");

    // No host byte without a successful pop
    a_host_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_host_byte_valid) |-> (o_host_byte == '0))
        else $error("host byte nonzero without valid");

    // While busy the status word shows busy alone
    a_busy_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status[ST_BUSY_BIT]) |-> (o_status == t_byte'(1 << ST_BUSY_BIT)))
        else $error("busy status carries other flags");

    // A stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)
            && $stable(o_read_byte) && $stable(o_tx_level) && $stable(o_rx_level)))
        else $error("stalled result changed");

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind console_uart_with_fifos cuart_checker u_cuart_checker (.*);
